// ===== rtl/core/cqra_pkg.sv =====
`default_nettype none

package cqra_pkg;

   // Fixed field widths
   localparam int ID_W   = 16;
   localparam int RATE_W = 8;

   // The rounded mean never exceeds the largest rate, so the quotient is one rate wide
   localparam int QUOT_W = RATE_W;
   localparam int STEP_W = $clog2(QUOT_W);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;      // latch the incoming transaction
      logic execute;      // update queue, pointers and running sum
      logic div_load;     // load dividend and shifted divisor
      logic div_step;     // one restoring-division step
      logic load_output;  // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_remove;    // captured command is a remove
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/cqra_ctrl.sv =====
`default_nettype none

module cqra_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire cqra_pkg::status_type status,
   output cqra_pkg::cmd_type        cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [cqra_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;

   // Output register can take a new result when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = status.is_remove ? ST_FINISH : ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == cqra_pkg::STEP_W'(cqra_pkg::QUOT_W - 1)) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_output = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cqra_datapath.sv =====
`default_nettype none

module cqra_datapath #(
   parameter int QUEUE_DEPTH = 5,
   parameter int OCC_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_command,
   input  wire logic [cqra_pkg::ID_W-1:0]   req_record_id,
   input  wire logic [cqra_pkg::RATE_W-1:0] req_rate_value,
   input  wire cqra_pkg::cmd_type           cmd,
   output cqra_pkg::status_type             status,
   output logic [cqra_pkg::RATE_W-1:0]      rsp_mean_rate,
   output logic [cqra_pkg::ID_W-1:0]        rsp_removed_id,
   output logic [cqra_pkg::RATE_W-1:0]      rsp_removed_rate,
   output logic                             rsp_empty_error,
   output logic [OCC_W-1:0]                 rsp_occupancy_out
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SUM_W  = $clog2(((1 << cqra_pkg::RATE_W) - 1) * QUEUE_DEPTH + 1);
   localparam int NUM_W  = SUM_W + 2;
   localparam int DEN_W  = OCC_W + cqra_pkg::QUOT_W;
   localparam int CMP_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int RATE_W = cqra_pkg::RATE_W;
   localparam int ID_W   = cqra_pkg::ID_W;
   localparam int QUOT_W = cqra_pkg::QUOT_W;

   // Slot storage, read registered at the head pointer
   logic [ID_W-1:0]   slot_ids_ff   [QUEUE_DEPTH];
   logic [RATE_W-1:0] slot_rates_ff [QUEUE_DEPTH];
   logic [ID_W-1:0]   head_id_ff;
   logic [RATE_W-1:0] head_rate_ff;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic              command_ff, command_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [RATE_W-1:0] rate_ff, rate_in;

   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [RATE_W-1:0] res_rate_ff, res_rate_in;
   logic              res_err_ff, res_err_in;

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [RATE_W-1:0] out_mean_ff, out_mean_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic [RATE_W-1:0] out_rate_ff, out_rate_in;
   logic              out_err_ff, out_err_in;
   logic [OCC_W-1:0]  out_occ_ff, out_occ_in;

   logic              full;
   logic [CMP_W-1:0]  num_ext, den_ext;
   logic              fits;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.is_remove = command_ff;

   assign full    = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign num_ext = CMP_W'(num_ff);
   assign den_ext = CMP_W'(den_ff);
   assign fits    = (num_ext >= den_ext);

   // Next-state logic
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      sum_in      = sum_ff;
      command_in  = command_ff;
      id_in       = id_ff;
      rate_in     = rate_ff;
      res_id_in   = res_id_ff;
      res_rate_in = res_rate_ff;
      res_err_in  = res_err_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      quot_in     = quot_ff;
      out_mean_in = out_mean_ff;
      out_id_in   = out_id_ff;
      out_rate_in = out_rate_ff;
      out_err_in  = out_err_ff;
      out_occ_in  = out_occ_ff;

      // Latch the transaction
      if (cmd.capture) begin
         command_in = req_command;
         id_in      = req_record_id;
         rate_in    = req_rate_value;
      end

      // Queue update; a full insert drops the oldest entry first
      if (cmd.execute) begin
         res_id_in   = '0;
         res_rate_in = '0;
         res_err_in  = 1'b0;
         if (!command_ff) begin
            sum_in  = sum_ff - (full ? SUM_W'(head_rate_ff) : '0) + SUM_W'(rate_ff);
            head_in = full ? next_slot(head_ff) : head_ff;
            tail_in = next_slot(tail_ff);
            occ_in  = full ? occ_ff : occ_ff + 1'b1;
         end else if (occ_ff == '0) begin
            res_err_in = 1'b1;
         end else begin
            res_id_in   = head_id_ff;
            res_rate_in = head_rate_ff;
            head_in     = next_slot(head_ff);
            occ_in      = occ_ff - 1'b1;
            sum_in      = sum_ff - SUM_W'(head_rate_ff);
         end
      end

      // Rounded mean: (2*sum + occ) / (2*occ), quotient bits msb first
      if (cmd.div_load) begin
         num_in  = NUM_W'({sum_ff, 1'b0}) + NUM_W'(occ_ff);
         den_in  = {occ_ff, 1'b0, {(QUOT_W - 1){1'b0}}};
         quot_in = '0;
      end
      if (cmd.div_step) begin
         if (fits) begin
            num_in = NUM_W'(num_ext - den_ext);
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         den_in  = den_ff >> 1;
      end

      // Output register
      if (cmd.load_output) begin
         out_mean_in = command_ff ? '0 : quot_ff;
         out_id_in   = res_id_ff;
         out_rate_in = res_rate_ff;
         out_err_in  = res_err_ff;
         out_occ_in  = occ_ff;
      end
   end

   // Slot memory
   always_ff @(posedge clock) begin
      if (cmd.execute && !command_ff) begin
         slot_ids_ff[tail_ff]   <= id_ff;
         slot_rates_ff[tail_ff] <= rate_ff;
      end
      head_id_ff   <= slot_ids_ff[head_ff];
      head_rate_ff <= slot_rates_ff[head_ff];
   end

   // Queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         sum_ff  <= sum_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      command_ff  <= command_in;
      id_ff       <= id_in;
      rate_ff     <= rate_in;
      res_id_ff   <= res_id_in;
      res_rate_ff <= res_rate_in;
      res_err_ff  <= res_err_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      quot_ff     <= quot_in;
      out_mean_ff <= out_mean_in;
      out_id_ff   <= out_id_in;
      out_rate_ff <= out_rate_in;
      out_err_ff  <= out_err_in;
      out_occ_ff  <= out_occ_in;
   end

   assign rsp_mean_rate     = out_mean_ff;
   assign rsp_removed_id    = out_id_ff;
   assign rsp_removed_rate  = out_rate_ff;
   assign rsp_empty_error   = out_err_ff;
   assign rsp_occupancy_out = out_occ_ff;

endmodule

`default_nettype wire

// ===== rtl/core/circular_queue_running_average.sv =====
// Circular queue of (id, rate) records with a running rounded mean.
// Input channel req_*: valid/stall; a transaction is taken when req_valid is
// high and req_stall is low. req_command 0 inserts req_record_id and
// req_rate_value (dropping the oldest entry if full); 1 removes the oldest.
// Result channel rsp_*: one result per transaction, held while rsp_stall is high.
// An insert result carries the rounded mean of the held rates; a remove result
// carries the popped id and rate, or rsp_empty_error on an empty queue.
// Sequencing: the block works on one transaction at a time. An insert steps
// through the accepting cycle, update, divider load, eight steps of the serial
// restoring divider and output load; a remove steps through the accepting
// cycle, update and output load. Each result is then held in the output register.
// A new transaction is taken in the cycle after the result is loaded, even
// while that result is still stalled. If the receiver stalls, the finished
// result waits in the output register and the next result waits in the
// finish step until the register frees up.
// Reset (synchronous, active high) empties the queue, clears the running sum
// and drops any pending result; slot contents are not cleared.
`default_nettype none

module circular_queue_running_average #(
   parameter  int QUEUE_DEPTH = 5,
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_command,
   input  wire logic [cqra_pkg::ID_W-1:0]   req_record_id,
   input  wire logic [cqra_pkg::RATE_W-1:0] req_rate_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [cqra_pkg::RATE_W-1:0]      rsp_mean_rate,
   output logic [cqra_pkg::ID_W-1:0]        rsp_removed_id,
   output logic [cqra_pkg::RATE_W-1:0]      rsp_removed_rate,
   output logic                             rsp_empty_error,
   output logic [OCC_W-1:0]                 rsp_occupancy_out
);

   cqra_pkg::cmd_type    cmd;
   cqra_pkg::status_type status;

   cqra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cqra_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .OCC_W       (OCC_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_record_id     (req_record_id),
      .req_rate_value    (req_rate_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_mean_rate     (rsp_mean_rate),
      .rsp_removed_id    (rsp_removed_id),
      .rsp_removed_rate  (rsp_removed_rate),
      .rsp_empty_error   (rsp_empty_error),
      .rsp_occupancy_out (rsp_occupancy_out)
   );

   // An accepted transaction blocks the input on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepting a transaction");

   // An empty-queue error leaves every other field at zero
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_error) |->
         (rsp_mean_rate == '0 && rsp_removed_id == '0 &&
          rsp_removed_rate == '0 && rsp_occupancy_out == '0))
      else $error("empty error result carries data");

   // A nonzero mean only comes from an insert, which leaves at least one entry
   a_mean_from_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mean_rate != '0) |->
         (!rsp_empty_error && rsp_removed_id == '0 && rsp_occupancy_out != '0))
      else $error("mean reported on a non-insert result");

   // Occupancy never exceeds the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy_out <= OCC_W'(QUEUE_DEPTH)))
      else $error("occupancy above queue depth");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;

   localparam int ID_W        = cqra_pkg::ID_W;
   localparam int RATE_W      = cqra_pkg::RATE_W;
   localparam int DEPTH       = 5;
   localparam int OCC_W       = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 200;
   localparam int DRAIN_WAIT  = 30;

   // Command codes on req_command
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef struct packed {
      logic [RATE_W-1:0] mean_rate;
      logic [ID_W-1:0]   removed_id;
      logic [RATE_W-1:0] removed_rate;
      logic              empty_error;
      logic [OCC_W-1:0]  occupancy;
   } queue_reply_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_command = CMD_INSERT;
   logic [ID_W-1:0]   req_record_id = '0;
   logic [RATE_W-1:0] req_rate_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [RATE_W-1:0] rsp_mean_rate;
   logic [ID_W-1:0]   rsp_removed_id;
   logic [RATE_W-1:0] rsp_removed_rate;
   logic              rsp_empty_error;
   logic [OCC_W-1:0]  rsp_occupancy_out;

   // Shadow copy of the queue contents
   logic [ID_W-1:0]   shadow_ids[DEPTH];
   logic [RATE_W-1:0] shadow_rates[DEPTH];
   int                head_slot = 0;
   int                tail_slot = 0;
   int                held_count = 0;
   int                held_sum = 0;

   queue_reply_type replies_due[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   bit           gaps_on = 1'b1;
   int           hold_requests = 0;
   int           hold_served = 0;
   int           hold_left = 0;

   circular_queue_running_average #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_record_id    (req_record_id),
      .req_rate_value   (req_rate_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mean_rate    (rsp_mean_rate),
      .rsp_removed_id   (rsp_removed_id),
      .rsp_removed_rate (rsp_removed_rate),
      .rsp_empty_error  (rsp_empty_error),
      .rsp_occupancy_out(rsp_occupancy_out)
   );

   // Clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result stall: long hold-off on request, else random idling
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_LEN;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!gaps_on) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 22);
      end
   end

   // Pop the oldest entry out of the shadow queue
   function automatic void retire_head();
      held_sum  -= shadow_rates[head_slot];
      head_slot  = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
      held_count--;
   endfunction

   // Update the shadow queue for one accepted transaction and queue the reply it owes
   function automatic void apply_queue_op(logic cmd, logic [ID_W-1:0] id,
                                          logic [RATE_W-1:0] rate);
      queue_reply_type reply;
      reply = '0;
      if (cmd == CMD_INSERT) begin
         // full queue loses its oldest entry without a report
         if (held_count >= DEPTH) retire_head();
         shadow_ids[tail_slot]   = id;
         shadow_rates[tail_slot] = rate;
         tail_slot = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
         held_count++;
         held_sum += rate;
         // rounded half up
         reply.mean_rate = RATE_W'((2 * held_sum + held_count) / (2 * held_count));
      end else if (held_count == 0) begin
         reply.empty_error = 1'b1;
      end else begin
         reply.removed_id   = shadow_ids[head_slot];
         reply.removed_rate = shadow_rates[head_slot];
         retire_head();
      end
      reply.occupancy = OCC_W'(held_count);
      replies_due.push_back(reply);
   endfunction

   function automatic void check_field(string name, logic [ID_W-1:0] got,
                                       logic [ID_W-1:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   // Result checker
   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (replies_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction: mean %0h id %0h rate %0h",
                        rsp_mean_rate, rsp_removed_id, rsp_removed_rate);
         end else begin
            want = replies_due.pop_front();
            check_field("mean_rate", ID_W'(rsp_mean_rate), ID_W'(want.mean_rate));
            check_field("removed_id", rsp_removed_id, want.removed_id);
            check_field("removed_rate", ID_W'(rsp_removed_rate), ID_W'(want.removed_rate));
            check_field("empty_error", ID_W'(rsp_empty_error), ID_W'(want.empty_error));
            check_field("occupancy", ID_W'(rsp_occupancy_out), ID_W'(want.occupancy));
         end
      end
   end

   // Offer one transaction; valid stays high on return
   task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                            input logic [RATE_W-1:0] rate);
      if (gaps_on && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_record_id  <= id;
      req_rate_value <= rate;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_queue_op(cmd, id, rate);
   endtask

   // Stop offering and wait until every owed result has been seen
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [RATE_W-1:0] pick_rate();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      return RATE_W'($urandom);
   endfunction

   task automatic test_empty_remove();
      send_item(CMD_REMOVE, 16'hFFFF, 8'hFF);
      send_item(CMD_REMOVE, 16'h1357, 8'h5A);
   endtask

   // Extremes, overfill with silent drop, pointer wrap, drain to empty
   task automatic test_fill_and_wrap();
      send_item(CMD_INSERT, 16'h0000, 8'd0);
      send_item(CMD_INSERT, 16'hFFFF, 8'd255);
      send_item(CMD_INSERT, 16'h1234, 8'd1);
      send_item(CMD_INSERT, 16'hA5A5, 8'd2);
      send_item(CMD_INSERT, 16'h5A5A, 8'd255);
      send_item(CMD_INSERT, 16'h0001, 8'd255);
      send_item(CMD_INSERT, 16'hFFFE, 8'd255);
      send_item(CMD_INSERT, 16'h8000, 8'd255);
      send_item(CMD_INSERT, 16'h7FFF, 8'd255);
      repeat (DEPTH) send_item(CMD_REMOVE, 16'($urandom), 8'($urandom));
      send_item(CMD_REMOVE, 16'hFFFF, 8'hFF);
   endtask

   // Half-way mean rounds up
   task automatic test_rounding();
      send_item(CMD_INSERT, 16'h0F0F, 8'd1);
      send_item(CMD_INSERT, 16'hF0F0, 8'd2);
      send_item(CMD_REMOVE, 16'h0000, 8'd0);
      send_item(CMD_REMOVE, 16'h0000, 8'd0);
      send_item(CMD_REMOVE, 16'h0000, 8'd0);
   endtask

   // Receiver holds off while the sender keeps offering
   task automatic test_result_holdoff();
      gaps_on = 1'b0;
      hold_requests <= hold_requests + 1;
      for (int n = 0; n < 14; n++)
         send_item(($urandom_range(99) < 30) ? CMD_REMOVE : CMD_INSERT,
                   16'($urandom), pick_rate());
      gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      for (int n = 0; n < 6; n++) send_item(CMD_INSERT, 16'($urandom), pick_rate());
      wait_for_drain();
      for (int n = 0; n < 4; n++) send_item(CMD_REMOVE, 16'($urandom), 8'($urandom));
   endtask

   // Segments are balanced or lean toward inserts or removes so the queue swings between full and empty
   task automatic test_random_traffic(input int count);
      int  mode;
      int  seg_left;
      int  remove_pct;
      logic cmd;
      seg_left = 0;
      mode     = 0;
      for (int n = 0; n < count; n++) begin
         if (seg_left == 0) begin
            mode     = $urandom_range(2);
            seg_left = $urandom_range(6, 20);
         end
         seg_left--;
         remove_pct = (mode == 0) ? 50 : (mode == 1) ? 15 : 80;
         cmd = ($urandom_range(99) < remove_pct) ? CMD_REMOVE : CMD_INSERT;
         send_item(cmd, 16'($urandom), pick_rate());
      end
   endtask

   task automatic test_quiet_stretch();
      gaps_on = 1'b0;
      test_random_traffic(250);
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_remove();
      test_fill_and_wrap();
      test_rounding();
      test_random_traffic(300);
      test_result_holdoff();
      test_sender_pause();
      test_quiet_stretch();
      test_random_traffic(500);
      wait_for_drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && replies_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
